FILE: rtl/snro_pkg.sv
package snro_pkg;

	localparam int MIN_PACKET_BYTES = 48;
	localparam int MAX_PACKET_BYTES = 68;
	localparam int SAMPLE_LIMIT     = 16;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_LOSS  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] SS_RUN  = 2'd0;
	localparam logic [1:0] SS_DONE = 2'd1;
	localparam logic [1:0] SS_FAIL = 2'd2;

	localparam logic [2:0] REG_SAMPLE_COUNT = 3'd0;
	localparam logic [2:0] REG_INSANITY     = 3'd1;
	localparam logic [2:0] REG_MIN_ERROR    = 3'd2;
	localparam logic [2:0] REG_MAX_VERSION  = 3'd3;
	localparam logic [2:0] REG_MAX_STRATUM  = 3'd4;

	localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] SMIN = {1'b1, {63{1'b0}}};

	typedef enum logic [1:0] {
		JOB_START,
		JOB_REPLY,
		JOB_LOSS
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [6:0]  last_idx;
		logic [31:0] header;
		logic [31:0] disp;
		logic [63:0] ref_ts;
		logic [63:0] orig_ts;
		logic [63:0] recv_ts;
		logic [63:0] xmit_ts;
		logic [63:0] now;
	} job_t;

	typedef struct packed {
		logic [4:0]  sample_count;
		logic [31:0] insanity_seconds;
		logic [31:0] min_error;
		logic [2:0]  max_version;
		logic [7:0]  max_stratum;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  packet_byte;
		logic        byte_last;
		logic [63:0] local_receive_time;
	} in_item_t;

	typedef struct packed {
		logic               reply_status;
		logic signed [63:0] reply_offset;
		logic signed [63:0] reply_error;
		logic [1:0]         session_state;
		logic signed [63:0] best_offset;
		logic signed [63:0] best_error;
		logic [31:0]        max_dispersion;
	} out_item_t;

	// clamp a 65-bit signed value into signed 64 bits
	function automatic logic [63:0] sat65(input logic [64:0] d);
		logic [63:0] r;
		if (d[64] != d[63]) begin
			r = d[64] ? SMIN : SMAX;
		end else begin
			r = d[63:0];
		end
		return r;
	endfunction

	function automatic logic [4:0] eff_count(input logic [4:0] c);
		logic [4:0] r;
		r = c;
		if (c == 5'd0) begin
			r = 5'd1;
		end else if (c > 5'(SAMPLE_LIMIT)) begin
			r = 5'(SAMPLE_LIMIT);
		end
		return r;
	endfunction

endpackage

FILE: rtl/sntp_reply_offset_filter.sv
// Channel   Handshake              Payload
// input     push / full            in_item  (op, packet_byte, byte_last, local_receive_time)
// result    empty / pop            out_item (reply status, offset, error, session summary)
// config    psel/penable/pwrite    paddr, pwdata, prdata, pready (always high)
//
// Input beats are taken one per cycle, back to back, while full is low. A last
// byte, a loss or a start becomes a job in a two-entry queue; the back end takes
// a reply or loss job through pop, check, arithmetic, error, update, decision and
// hand-off, and a start, or a job after the session has ended, through pop and
// check only. full rises only while the job queue holds two jobs: jobs that come
// faster than the back end finishes them (short replies, runs of losses) or a
// result left unpopped.
// Reset is asynchronous, active low; no clearing pass is needed.
module sntp_reply_offset_filter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  snro_pkg::in_item_t   in_item,
	output logic                 empty,
	input  logic                 pop,
	output snro_pkg::out_item_t  out_item,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import snro_pkg::*;

	cfg_t cfg_q;
	logic [2:0] ridx;
	assign ridx   = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_count     <= 5'd16;
			cfg_q.insanity_seconds <= 32'd3600000;
			cfg_q.min_error        <= 32'd429496730;
			cfg_q.max_version      <= 3'd4;
			cfg_q.max_stratum      <= 8'd15;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_SAMPLE_COUNT: cfg_q.sample_count     <= pwdata[4:0];
				REG_INSANITY:     cfg_q.insanity_seconds <= pwdata;
				REG_MIN_ERROR:    cfg_q.min_error        <= pwdata;
				REG_MAX_VERSION:  cfg_q.max_version      <= pwdata[2:0];
				REG_MAX_STRATUM:  cfg_q.max_stratum      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_SAMPLE_COUNT: prdata = {27'd0, cfg_q.sample_count};
			REG_INSANITY:     prdata = cfg_q.insanity_seconds;
			REG_MIN_ERROR:    prdata = cfg_q.min_error;
			REG_MAX_VERSION:  prdata = {29'd0, cfg_q.max_version};
			REG_MAX_STRATUM:  prdata = {24'd0, cfg_q.max_stratum};
			default:          prdata = 32'd0;
		endcase
	end

	logic jq_push, jq_pop, jq_empty, jq_full, take, res_valid;
	job_t job, jq_head;

	// only a full job queue holds the input
	assign full  = jq_full;
	assign take  = push && !full;
	assign empty = !res_valid;

	snro_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (in_item),
		.job_push (jq_push),
		.job      (job)
	);

	snro_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (jq_push),
		.wdata  (job),
		.rd_en  (jq_pop),
		.rdata  (jq_head),
		.empty  (jq_empty),
		.full   (jq_full)
	);

	snro_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.jq_empty  (jq_empty),
		.jq_head   (jq_head),
		.jq_pop    (jq_pop),
		.res_valid (res_valid),
		.res       (out_item),
		.res_pop   (pop)
	);

endmodule

FILE: rtl/snro_front.sv
module snro_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  snro_pkg::in_item_t  item,
	output logic                job_push,
	output snro_pkg::job_t      job
);
	import snro_pkg::*;

	logic [6:0]  idx_q;
	logic [31:0] hdr_q, disp_q;
	logic [63:0] ref_q, orig_q, recv_q, xmit_q;
	logic [31:0] hdr_n, disp_n;
	logic [63:0] ref_n, orig_n, recv_n, xmit_n;
	logic [63:0] lane;
	logic [5:0]  sh;

	// place the byte into its field
	always_comb begin
		hdr_n  = hdr_q;
		disp_n = disp_q;
		ref_n  = ref_q;
		orig_n = orig_q;
		recv_n = recv_q;
		xmit_n = xmit_q;
		sh     = 6'd56 - {idx_q[2:0], 3'b000};
		lane   = 64'd0;
		if (idx_q < 7'd4) begin
			hdr_n[5'd24 - {idx_q[1:0], 3'b000} +: 8] = item.packet_byte;
		end else if (idx_q >= 7'd8 && idx_q < 7'd12) begin
			disp_n[5'd24 - {idx_q[1:0], 3'b000} +: 8] = item.packet_byte;
		end else if (idx_q >= 7'd16 && idx_q < 7'd48) begin
			lane = ref_q;
			case (idx_q[5:3])
				3'd2: lane = ref_q;
				3'd3: lane = orig_q;
				3'd4: lane = recv_q;
				3'd5: lane = xmit_q;
				default: lane = ref_q;
			endcase
			lane[sh +: 8] = item.packet_byte;
			case (idx_q[5:3])
				3'd2: ref_n  = lane;
				3'd3: orig_n = lane;
				3'd4: recv_n = lane;
				3'd5: xmit_n = lane;
				default: ref_n = ref_q;
			endcase
		end
	end

	// bytes are taken whatever the session state; the back end drops jobs
	// of a session that has ended, and a start clears the byte index
	logic is_byte, is_loss, is_start;
	assign is_start = take && item.op == OP_START;
	assign is_byte  = take && item.op == OP_BYTE;
	assign is_loss  = take && item.op == OP_LOSS;

	assign job_push = is_start || is_loss || (is_byte && item.byte_last);

	always_comb begin
		job.kind     = is_start ? JOB_START : (is_loss ? JOB_LOSS : JOB_REPLY);
		job.last_idx = idx_q;
		job.header   = hdr_n;
		job.disp     = disp_n;
		job.ref_ts   = ref_n;
		job.orig_ts  = orig_n;
		job.recv_ts  = recv_n;
		job.xmit_ts  = xmit_n;
		job.now      = item.local_receive_time;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			hdr_q  <= '0;
			disp_q <= '0;
			ref_q  <= '0;
			orig_q <= '0;
			recv_q <= '0;
			xmit_q <= '0;
		end else if (is_start || is_loss) begin
			idx_q <= '0;
		end else if (is_byte) begin
			hdr_q  <= hdr_n;
			disp_q <= disp_n;
			ref_q  <= ref_n;
			orig_q <= orig_n;
			recv_q <= recv_n;
			xmit_q <= xmit_n;
			if (item.byte_last) begin
				idx_q <= '0;
			end else if (idx_q != 7'd127) begin
				idx_q <= idx_q + 7'd1;
			end
		end
	end

endmodule

FILE: rtl/snro_jobq.sv
module snro_jobq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  snro_pkg::job_t  wdata,
	input  logic            rd_en,
	output snro_pkg::job_t  rdata,
	output logic            empty,
	output logic            full
);
	import snro_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign empty = cnt_q == 2'd0;
	assign full  = cnt_q == 2'd2;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en && !full) begin
				wp_q <= ~wp_q;
			end
			if (rd_en && !empty) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(wr_en && !full) - 2'(rd_en && !empty);
		end
	end

endmodule

FILE: rtl/snro_back.sv
module snro_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  snro_pkg::cfg_t       cfg,
	input  logic                 jq_empty,
	input  snro_pkg::job_t       jq_head,
	output logic                 jq_pop,
	output logic                 res_valid,
	output snro_pkg::out_item_t  res,
	input  logic                 res_pop
);
	import snro_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CHK,
		B_ARITH,
		B_ERR,
		B_UPD,
		B_FIN,
		B_OUT
	} bstate_t;

	bstate_t     state_q;
	job_t        j_q;
	logic        ok_q, lt_q;
	logic [63:0] x_q, y_q, half_q, off_q, err_q;
	logic [64:0] dif_q, a_q, bnd_q;
	logic [63:0] best_off_q, best_err_q;
	logic [31:0] maxd_q;
	logic [4:0]  acc_q;
	logic [5:0]  rej_q, att_q;
	logic [1:0]  status_q;
	out_item_t   res_q, out_q;
	logic        out_valid_q;

	logic [63:0] ins;
	assign ins = {cfg.insanity_seconds, 32'd0};

	assign jq_pop    = state_q == B_IDLE && !jq_empty;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// reply checks
	logic [1:0]  leap;
	logic [2:0]  ver, mode;
	logic [7:0]  strat;
	logic        chk_ok;
	logic [64:0] dx, dy;
	always_comb begin
		leap   = j_q.header[31:30];
		ver    = j_q.header[29:27];
		mode   = j_q.header[26:24];
		strat  = j_q.header[23:16];
		chk_ok = j_q.kind == JOB_REPLY
			&& j_q.last_idx >= 7'(MIN_PACKET_BYTES - 1)
			&& j_q.last_idx <= 7'(MAX_PACKET_BYTES - 1)
			&& (mode == 3'd4 || mode == 3'd5)
			&& leap == 2'd0 && ver != 3'd0 && ver <= cfg.max_version
			&& strat <= cfg.max_stratum
			&& !(strat != 8'd0 && strat != cfg.max_stratum && j_q.ref_ts == 64'd0)
			&& j_q.xmit_ts != 64'd0 && j_q.orig_ts != 64'd0 && j_q.recv_ts != 64'd0
			&& !(j_q.ref_ts != 64'd0 && j_q.recv_ts < j_q.ref_ts)
			&& j_q.xmit_ts >= j_q.recv_ts && (j_q.xmit_ts - j_q.recv_ts) <= ins
			&& j_q.now >= j_q.orig_ts
			&& {16'd0, j_q.disp} <= {cfg.insanity_seconds, 16'd0};
		dx = {1'b0, j_q.recv_ts} - {1'b0, j_q.orig_ts};
		dy = {1'b0, j_q.xmit_ts} - {1'b0, j_q.now};
	end

	// session decision
	logic [4:0]  c;
	logic [63:0] as, absa, bnd, nbest_err, nbest_off, e_sat;
	logic [1:0]  nstat;
	logic        ends;
	always_comb begin
		c         = eff_count(cfg.sample_count);
		e_sat     = sat65(dif_q);
		as        = sat65(a_q);
		absa      = as;
		if (as[63]) begin
			absa = (as == SMIN) ? SMAX : (64'd0 - as);
		end
		if (acc_q <= 5'd1) begin
			absa = 64'd0;
		end
		bnd       = sat65(bnd_q);
		nbest_err = lt_q ? err_q : best_err_q;
		nbest_off = lt_q ? off_q : best_off_q;
		if (!ok_q) begin
			nbest_err = best_err_q;
			nbest_off = best_off_q;
		end
		ends  = !(acc_q < c && att_q < {c, 1'b0});
		nstat = status_q;
		if (ends) begin
			nstat = (acc_q == 5'd0 || $signed(nbest_err) > $signed(ins)) ? SS_FAIL : SS_DONE;
		end
		if (!ok_q) begin
			if (rej_q > {1'b0, c}) begin
				nstat = SS_FAIL;
			end
		end else if ($signed(absa) > $signed(bnd)) begin
			nstat = SS_FAIL;
		end else if ($signed(nbest_err) <= $signed({32'd0, cfg.min_error})) begin
			nstat = ($signed(nbest_err) > $signed(ins)) ? SS_FAIL : SS_DONE;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!jq_empty) begin
					j_q <= jq_head;
				end
			end
			B_CHK: begin
				ok_q   <= chk_ok;
				x_q    <= sat65(dx);
				y_q    <= sat65(dy);
				half_q <= {1'b0, 63'((j_q.now - j_q.orig_ts) >> 1)};
			end
			B_ARITH: begin
				off_q <= 64'(({x_q[63], x_q} + {y_q[63], y_q}) >> 1);
				dif_q <= {x_q[63], x_q} - {y_q[63], y_q};
			end
			B_ERR: begin
				err_q <= ($signed(half_q) > $signed(e_sat)) ? half_q : e_sat;
			end
			B_UPD: begin
				a_q   <= {off_q[63], off_q} - {best_off_q[63], best_off_q};
				bnd_q <= {best_err_q[63], best_err_q} + {err_q[63], err_q};
				lt_q  <= $signed(err_q) < $signed(best_err_q);
			end
			B_FIN: begin
				res_q.reply_status   <= !ok_q;
				res_q.reply_offset   <= ok_q ? off_q : 64'd0;
				res_q.reply_error    <= ok_q ? err_q : 64'd0;
				res_q.session_state  <= nstat;
				res_q.best_offset    <= nbest_off;
				res_q.best_error     <= nbest_err;
				res_q.max_dispersion <= maxd_q;
			end
			default: begin
				ok_q <= ok_q;
			end
		endcase
		if (state_q == B_OUT && (!out_valid_q || res_pop)) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			best_off_q  <= '0;
			best_err_q  <= {32'd3600000, 32'd0};
			maxd_q      <= '0;
			acc_q       <= '0;
			rej_q       <= '0;
			att_q       <= '0;
			status_q    <= SS_RUN;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_OUT && (!out_valid_q || res_pop)) begin
				out_valid_q <= 1'b1;
			end else if (res_pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!jq_empty) begin
						state_q <= B_CHK;
					end
				end
				B_CHK: begin
					if (j_q.kind == JOB_START) begin
						best_off_q <= '0;
						best_err_q <= ins;
						maxd_q     <= '0;
						acc_q      <= '0;
						rej_q      <= '0;
						att_q      <= '0;
						status_q   <= SS_RUN;
						state_q    <= B_IDLE;
					end else if (status_q != SS_RUN) begin
						// session over: reply or loss is dropped without a result
						state_q <= B_IDLE;
					end else begin
						state_q <= B_ARITH;
					end
				end
				B_ARITH: state_q <= B_ERR;
				B_ERR:   state_q <= B_UPD;
				B_UPD: begin
					if (att_q != 6'd63) begin
						att_q <= att_q + 6'd1;
					end
					if (ok_q) begin
						if (acc_q != 5'd31) begin
							acc_q <= acc_q + 5'd1;
						end
						if (j_q.disp > maxd_q) begin
							maxd_q <= j_q.disp;
						end
					end else if (rej_q != 6'd63) begin
						rej_q <= rej_q + 6'd1;
					end
					state_q <= B_FIN;
				end
				B_FIN: begin
					status_q   <= nstat;
					best_err_q <= nbest_err;
					best_off_q <= nbest_off;
					state_q    <= B_OUT;
				end
				B_OUT: begin
					if (!out_valid_q || res_pop) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.reply_status |->
			out_q.reply_offset == 64'd0 && out_q.reply_error == 64'd0)
		else $error("rejected reply carries offset or error");

	a_err_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.reply_status |-> !out_q.reply_error[63])
		else $error("accepted reply with negative error");

	a_acc_cap: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= 5'(SAMPLE_LIMIT))
		else $error("accept count beyond sample limit");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		jq_pop |=> state_q == B_CHK)
		else $error("job taken without check step");

endmodule

FILE: test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import snro_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic push, full, empty, pop;
	in_item_t in_item;
	out_item_t out_item;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	sntp_reply_offset_filter uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// shadow configuration
	logic [4:0]  m_samples;
	logic [31:0] m_insane, m_minerr;
	logic [2:0]  m_maxver;
	logic [7:0]  m_maxstr;

	// shadow block state
	logic [6:0]  m_idx;
	logic [31:0] m_hdr, m_disp;
	logic [63:0] m_ref, m_orig, m_recv, m_xmit;
	logic signed [63:0] m_best_off, m_best_err;
	logic [31:0] m_max_disp;
	logic [5:0]  m_acc, m_rej, m_att;
	logic [1:0]  m_sess;

	in_item_t  beat_q[$];
	out_item_t result_q[$];
	int errors, accepted_in, accepted_out, n_accepts, n_done, n_fail;
	int idle_cycles;
	bit calm;

	function automatic logic signed [63:0] sat_diff65(logic [64:0] d);
		if (d[64] != d[63]) return d[64] ? SMIN : SMAX;
		return d[63:0];
	endfunction

	function automatic logic signed [63:0] diff_sat(logic [63:0] a, logic [63:0] b);
		return sat_diff65({1'b0, a} - {1'b0, b});
	endfunction

	function automatic logic signed [63:0] ssub(logic signed [63:0] a, logic signed [63:0] b);
		return sat_diff65({a[63], a} - {b[63], b});
	endfunction

	function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
		return sat_diff65({a[63], a} + {b[63], b});
	endfunction

	function automatic int unsigned clamp_samples();
		if (m_samples == 0) return 1;
		if (m_samples > SAMPLE_LIMIT) return SAMPLE_LIMIT;
		return m_samples;
	endfunction

	function automatic logic signed [63:0] insane_bound();
		return {m_insane, 32'd0};
	endfunction

	// end-of-session rule on attempt or accept count
	function automatic void session_end_check();
		int unsigned c;
		c = clamp_samples();
		if (m_acc < c && m_att < 2 * c) return;
		if (m_acc == 0 || m_best_err > insane_bound()) m_sess = SS_FAIL;
		else m_sess = SS_DONE;
	endfunction

	function automatic bit reply_ok(logic [63:0] now, output logic signed [63:0] off,
			output logic signed [63:0] err);
		int unsigned len;
		logic [1:0] leap;
		logic [2:0] ver, mode;
		logic [7:0] strat;
		logic [63:0] ins;
		logic signed [63:0] x, y, half;
		len = m_idx + 1;
		leap = m_hdr[31:30];
		ver = m_hdr[29:27];
		mode = m_hdr[26:24];
		strat = m_hdr[23:16];
		ins = {m_insane, 32'd0};
		off = 0;
		err = 0;
		if (len < MIN_PACKET_BYTES || len > MAX_PACKET_BYTES) return 0;
		if (mode != 4 && mode != 5) return 0;
		if (leap != 0 || ver < 1 || ver > m_maxver || strat > m_maxstr) return 0;
		if (strat != 0 && strat != m_maxstr && m_ref == 0) return 0;
		if (m_xmit == 0 || m_orig == 0 || m_recv == 0) return 0;
		if (m_ref != 0 && m_recv < m_ref) return 0;
		if (m_xmit < m_recv || m_xmit - m_recv > ins) return 0;
		if (now < m_orig) return 0;
		if ({32'd0, m_disp} > {16'd0, m_insane, 16'd0}) return 0;
		x = diff_sat(m_recv, m_orig);
		y = diff_sat(m_xmit, now);
		// exact floor((x+y)/2) via 65-bit sum
		off = 64'(({x[63], x} + {y[63], y}) >>> 1);
		err = ssub(x, y);
		half = (now - m_orig) >> 1;
		if (half > err) err = half;
		return 1;
	endfunction

	function automatic void predict(in_item_t it);
		out_item_t r;
		bit ok;
		logic signed [63:0] off, err, a, bound;
		int unsigned p, c, sh;
		if (it.op == OP_START) begin
			m_idx = 0;
			m_best_off = 0;
			m_best_err = insane_bound();
			m_max_disp = 0;
			m_acc = 0;
			m_rej = 0;
			m_att = 0;
			m_sess = SS_RUN;
			return;
		end
		if (it.op == OP_NONE || m_sess != SS_RUN) return;
		ok = 0;
		off = 0;
		err = 0;
		if (it.op == OP_BYTE) begin
			p = m_idx;
			if (p < 4) m_hdr[8*(3-p) +: 8] = it.packet_byte;
			else if (p >= 8 && p < 12) m_disp[8*(11-p) +: 8] = it.packet_byte;
			else if (p >= 16 && p < 48) begin
				sh = 8 * (7 - (p % 8));
				if (p < 24) m_ref[sh +: 8] = it.packet_byte;
				else if (p < 32) m_orig[sh +: 8] = it.packet_byte;
				else if (p < 40) m_recv[sh +: 8] = it.packet_byte;
				else m_xmit[sh +: 8] = it.packet_byte;
			end
			if (!it.byte_last) begin
				if (m_idx < 127) m_idx++;
				return;
			end
			ok = reply_ok(it.local_receive_time, off, err);
		end
		m_idx = 0;
		c = clamp_samples();
		if (m_att < 63) m_att++;
		if (!ok) begin
			off = 0;
			err = 0;
			if (m_rej < 63) m_rej++;
			if (m_rej > c) m_sess = SS_FAIL;
			else session_end_check();
		end else begin
			n_accepts++;
			if (m_disp > m_max_disp) m_max_disp = m_disp;
			if (m_acc < 31) m_acc++;
			a = ssub(off, m_best_off);
			if (a < 0) a = (a == SMIN) ? SMAX : -a;
			if (m_acc <= 1) a = 0;
			bound = sadd(m_best_err, err);
			if (err < m_best_err) begin
				m_best_off = off;
				m_best_err = err;
			end
			if (a > bound) m_sess = SS_FAIL;
			else if (m_best_err <= $signed({32'd0, m_minerr}))
				m_sess = (m_best_err > insane_bound()) ? SS_FAIL : SS_DONE;
			else session_end_check();
		end
		if (m_sess == SS_DONE) n_done++;
		if (m_sess == SS_FAIL) n_fail++;
		r.reply_status = !ok;
		r.reply_offset = off;
		r.reply_error = err;
		r.session_state = m_sess;
		r.best_offset = m_best_off;
		r.best_error = m_best_err;
		r.max_dispersion = m_max_disp;
		result_q.push_back(r);
	endfunction

	// ---------------- driver: one beat per accepted push ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			in_item <= '0;
		end else begin
			if (push && !full) begin
				predict(in_item);
				accepted_in++;
			end
			if (!(push && full)) begin
				if (beat_q.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
					in_item <= beat_q.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor: compare each popped result ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				accepted_out++;
				if (result_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %p", $time, out_item);
				end else begin
					out_item_t e;
					e = result_q.pop_front();
					if (out_item.reply_status !== e.reply_status)
						$display("%0t: reply_status exp %0d got %0d", $time,
							e.reply_status, out_item.reply_status);
					if (out_item.reply_offset !== e.reply_offset)
						$display("%0t: reply_offset exp %0h got %0h", $time,
							e.reply_offset, out_item.reply_offset);
					if (out_item.reply_error !== e.reply_error)
						$display("%0t: reply_error exp %0h got %0h", $time,
							e.reply_error, out_item.reply_error);
					if (out_item.session_state !== e.session_state)
						$display("%0t: session_state exp %0d got %0d", $time,
							e.session_state, out_item.session_state);
					if (out_item.best_offset !== e.best_offset)
						$display("%0t: best_offset exp %0h got %0h", $time,
							e.best_offset, out_item.best_offset);
					if (out_item.best_error !== e.best_error)
						$display("%0t: best_error exp %0h got %0h", $time,
							e.best_error, out_item.best_error);
					if (out_item.max_dispersion !== e.max_dispersion)
						$display("%0t: max_dispersion exp %0h got %0h", $time,
							e.max_dispersion, out_item.max_dispersion);
					if (out_item !== e) errors++;
				end
			end
			pop <= calm || $urandom_range(99) >= 8;
		end
	end

	// watchdog on beats in either direction and on register access
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("sntp_reply_offset_filter verification failed");
			$finish;
		end
	end

	// ---------------- stimulus helpers ----------------
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SAMPLE_COUNT: m_samples = val[4:0];
			REG_INSANITY:     m_insane = val;
			REG_MIN_ERROR:    m_minerr = val;
			REG_MAX_VERSION:  m_maxver = val[2:0];
			default:          m_maxstr = val[7:0];
		endcase
	endtask

	// block is quiet: queues drained, back end settled
	task automatic wait_quiet();
		while (beat_q.size() != 0 || push || result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void add_beat(logic [1:0] op, logic [7:0] b, bit last, logic [63:0] now);
		in_item_t it;
		it.op = op;
		it.packet_byte = b;
		it.byte_last = last;
		it.local_receive_time = now;
		beat_q.push_back(it);
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// build one reply; mostly well formed, with optional corruption
	function automatic void add_reply(bit wild, int len_force);
		logic [7:0] pkt[128];
		logic [63:0] t0, orig, recv, xmit, now, refs;
		int len, k;
		logic [2:0] mode, ver;
		logic [7:0] strat;
		t0 = {1'b0, 31'($urandom()), $urandom()};
		orig = t0 + $urandom_range(1, 1000000);
		recv = orig + {$urandom_range(0, 3), $urandom()} - 64'h1_0000_0000;
		xmit = recv + $urandom_range(0, 100000);
		now = orig + {$urandom_range(0, 2), $urandom()};
		refs = recv - $urandom_range(0, 1000);
		mode = $urandom_range(0, 1) ? 3'd4 : 3'd5;
		ver = 3'($urandom_range(1, m_maxver == 0 ? 1 : m_maxver));
		strat = 8'($urandom_range(0, m_maxstr));
		len = 48 + $urandom_range(0, 20);
		for (k = 0; k < 128; k++) pkt[k] = 8'($urandom());
		if (wild) begin
			orig = $urandom_range(0, 3) == 0 ? 64'd0 : rnd64();
			recv = rnd64();
			xmit = $urandom_range(0, 3) == 0 ? recv : rnd64();
			now = rnd64();
			refs = $urandom_range(0, 1) ? 64'd0 : rnd64();
			mode = 3'($urandom());
			ver = 3'($urandom());
			strat = 8'($urandom());
			len = $urandom_range(1, 128);
		end
		if (len_force > 0) len = len_force;
		pkt[0] = {(wild && $urandom_range(0, 3) == 0) ? 2'($urandom()) : 2'd0, ver, mode};
		pkt[1] = strat;
		pkt[8] = 8'd0;
		pkt[9] = 8'($urandom_range(0, 3));
		for (k = 0; k < 8; k++) begin
			pkt[16+k] = refs[63-8*k -: 8];
			pkt[24+k] = orig[63-8*k -: 8];
			pkt[32+k] = recv[63-8*k -: 8];
			pkt[40+k] = xmit[63-8*k -: 8];
		end
		for (k = 0; k < len; k++)
			add_beat(OP_BYTE, pkt[k], k == len - 1, k == len - 1 ? now : rnd64());
	endfunction

	// ---------------- sequence ----------------
	initial begin
		int k, ph;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		accepted_in = 0;
		accepted_out = 0;
		n_accepts = 0;
		n_done = 0;
		n_fail = 0;
		idle_cycles = 0;
		calm = 0;
		m_samples = 16;
		m_insane = 3600000;
		m_minerr = 429496730;
		m_maxver = 4;
		m_maxstr = 15;
		m_idx = 0;
		m_hdr = 0;
		m_disp = 0;
		m_ref = 0;
		m_orig = 0;
		m_recv = 0;
		m_xmit = 0;
		m_best_off = 0;
		m_best_err = 64'(3600000) << 32;
		m_max_disp = 0;
		m_acc = 0;
		m_rej = 0;
		m_att = 0;
		m_sess = SS_RUN;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: short replies, loss mid-reply, op 3, overlong, extremes
		add_beat(OP_NONE, 8'hFF, 1'b1, '1);
		add_beat(OP_START, 8'h00, 1'b0, '0);
		add_beat(OP_BYTE, 8'hFF, 1'b0, '1);
		add_beat(OP_LOSS, 8'h00, 1'b0, '0);
		add_reply(0, 0);
		add_reply(0, 47);
		add_reply(0, 128);
		add_beat(OP_LOSS, 8'hAA, 1'b1, '1);
		add_reply(0, 48);
		add_reply(0, 68);
		add_reply(0, 69);
		add_beat(OP_START, 8'hFF, 1'b1, '1);
		wait_quiet();

		// phases through several settings, the extremes among them
		for (ph = 0; ph < 8; ph++) begin
			calm = (ph == 3);
			case (ph)
				0: begin
					reg_write(REG_SAMPLE_COUNT, 1); reg_write(REG_INSANITY, 32'hFFFF_FFFF);
					reg_write(REG_MIN_ERROR, 0); reg_write(REG_MAX_VERSION, 7);
					reg_write(REG_MAX_STRATUM, 255);
				end
				1: begin
					reg_write(REG_SAMPLE_COUNT, 31); reg_write(REG_INSANITY, 1);
					reg_write(REG_MIN_ERROR, 32'hFFFF_FFFF); reg_write(REG_MAX_VERSION, 1);
					reg_write(REG_MAX_STRATUM, 0);
				end
				default: begin
					reg_write(REG_SAMPLE_COUNT, $urandom_range(0, 31));
					reg_write(REG_INSANITY, $urandom_range(0, 1) ? 3600000 : $urandom());
					reg_write(REG_MIN_ERROR,
						$urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom());
					reg_write(REG_MAX_VERSION, $urandom_range(0, 7));
					reg_write(REG_MAX_STRATUM, $urandom_range(0, 255));
				end
			endcase
			for (k = 0; k < 6; k++) begin
				add_beat(OP_START, 8'($urandom()), 1'($urandom()), rnd64());
				while (beat_q.size() < 200 * (k + 1) / 6) begin
					case ($urandom_range(0, 19))
						0: add_beat(OP_LOSS, 8'($urandom()), 1'($urandom()), rnd64());
						1: add_beat(OP_NONE, 8'($urandom()), 1'($urandom()), rnd64());
						2, 3: add_reply(1, 0);
						default: add_reply(0, 0);
					endcase
				end
			end
			// short queue feed keeps it simple: drain per phase
			wait_quiet();
		end
		wait_quiet();
		$display("beats in %0d, results %0d, good replies %0d", accepted_in, accepted_out,
			n_accepts);
		$display("sessions finished %0d, failed %0d", n_done, n_fail);
		if (errors == 0 && result_q.size() == 0) begin
			$display("sntp_reply_offset_filter verification clean");
		end else begin
			$display("sntp_reply_offset_filter verification failed");
		end
		$finish;
	end
endmodule
